// File: sv/csma_cd_bus_access_controller_assert.svh
// Assertion macros for the bus access controller.
// CCBA_ASSERT checks a property on the clock with reset masked out.
// CCBA_ASSERT_RST checks a property on the clock, reset included.
`ifndef CSMA_CD_BUS_ACCESS_CONTROLLER_ASSERT_SVH
`define CSMA_CD_BUS_ACCESS_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

`define CCBA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bus access controller assertion failed");

`define CCBA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("bus access controller reset assertion failed");

`else

`define CCBA_ASSERT(lbl, prop)

`define CCBA_ASSERT_RST(lbl, prop)

`endif

`endif

// File: sv/ccba_pkg.sv
`default_nettype none

package ccba_pkg;

    // Event codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_SEND    = 2'd2;
    localparam logic [1:0] OP_ECHO    = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_CD_BACKOFF = 3'd1;
    localparam logic [2:0] ST_PRIO_BACKOFF = 3'd2;
    localparam logic [2:0] ST_COLLISION = 3'd3;
    localparam logic [2:0] ST_NET_BUSY  = 3'd4;
    localparam logic [2:0] ST_GRANTED   = 3'd5;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_CD_BACKOFF     = 2'd0;
    localparam logic [1:0] CFG_COLLISION_HOLD = 2'd1;
    localparam logic [1:0] CFG_PRIO_TICK      = 2'd2;

    localparam logic [15:0] CD_BACKOFF_RST     = 16'd1200;
    localparam logic [15:0] COLLISION_HOLD_RST = 16'd900;
    localparam logic [7:0]  PRIO_TICK_RST      = 8'd60;

    // Bus mode
    typedef enum logic [2:0] {
        MODE_IDLE      = 3'b001,
        MODE_BACKOFF   = 3'b010,
        MODE_COLLISION = 3'b100
    } t_mode;

    typedef struct packed {
        logic [1:0] op;
        logic       line_busy;
        logic [7:0] prio_delay;
        logic [7:0] tx_byte;
        logic [7:0] echo_byte;
        logic       echo_present;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        send_break;
        logic [31:0] packets_sent;
        logic [31:0] collisions_seen;
    } t_out_item;

    // Status that reports a mode
    function automatic logic [2:0] mode_status(input t_mode mode);
        logic [2:0] st;
        unique case (mode)
            MODE_BACKOFF:   st = ST_CD_BACKOFF;
            MODE_COLLISION: st = ST_COLLISION;
            default:        st = ST_IDLE;
        endcase
        return st;
    endfunction

endpackage

`default_nettype wire

// File: sv/csma_cd_bus_access_controller.sv
`default_nettype none
// Each result is registered and is valid in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the single output register sets it and
// a new transaction is taken whenever that register is empty or being drained.
// Reset (i_rst_n low, synchronous): mode idle, counters and backoff state zero,
// config registers back to 1200 / 900 / 60, output register empty.

module csma_cd_bus_access_controller #(
    parameter int ELAPSED_BITS = 20
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  ccba_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output ccba_pkg::t_out_item  o_out_item,
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_idx,
    input  wire  [15:0]          i_cfg_data
);

    import ccba_pkg::*;

    `include "csma_cd_bus_access_controller_assert.svh"

    localparam logic [ELAPSED_BITS-1:0] EL_MAX = '1;

    // Configuration
    logic [15:0] r_cd_backoff;
    logic [15:0] r_coll_hold;
    logic [7:0]  r_prio_tick;

    // Bus state
    t_mode                   r_mode,     n_mode;
    logic [ELAPSED_BITS-1:0] r_elapsed,  n_elapsed;
    logic [15:0]             r_coll_left, n_coll_left;
    logic                    r_tx_active, n_tx_active;
    logic [31:0]             r_pkt_cnt,  n_pkt_cnt;
    logic [31:0]             r_coll_cnt, n_coll_cnt;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic [2:0]              n_status;
    logic                    n_break;
    logic                    load;
    logic [ELAPSED_BITS-1:0] elapsed_inc;
    logic [ELAPSED_BITS-1:0] cd_ext;
    logic [ELAPSED_BITS-1:0] full_ext;
    logic [15:0]             prio_prod;
    logic [16:0]             full_sum;
    logic                    echo_bad;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign load        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Arithmetic for the transaction cases
    assign elapsed_inc = (r_elapsed == EL_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign cd_ext      = ELAPSED_BITS'(r_cd_backoff);
    assign prio_prod   = {8'd0, i_in_item.prio_delay} * {8'd0, r_prio_tick};
    assign full_sum    = {1'b0, r_cd_backoff} + {1'b0, prio_prod};
    assign full_ext    = ELAPSED_BITS'(full_sum);
    assign echo_bad    = !i_in_item.echo_present ||
                         (i_in_item.echo_byte != i_in_item.tx_byte);

    // Next state and result for one transaction
    always_comb begin
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_coll_left = r_coll_left;
        n_tx_active = r_tx_active;
        n_pkt_cnt   = r_pkt_cnt;
        n_coll_cnt  = r_coll_cnt;
        n_status    = ST_IDLE;
        n_break     = 1'b0;

        unique case (i_in_item.op)
            OP_TICK: begin
                n_elapsed   = elapsed_inc;
                n_coll_left = (r_coll_left != 16'd0) ? r_coll_left - 16'd1 : r_coll_left;
                if (r_mode == MODE_BACKOFF && elapsed_inc >= cd_ext) begin
                    n_mode = MODE_IDLE;
                end else if (r_mode == MODE_COLLISION && n_coll_left == 16'd0) begin
                    n_mode = MODE_BACKOFF;
                end
                if (n_mode == MODE_IDLE && i_in_item.line_busy) begin
                    n_mode    = MODE_BACKOFF;
                    n_elapsed = '0;
                end
                n_status = mode_status(n_mode);
            end
            OP_RX_BYTE: begin
                n_mode    = MODE_BACKOFF;
                n_elapsed = '0;
                n_status  = ST_CD_BACKOFF;
            end
            OP_SEND: begin
                if (r_tx_active) begin
                    n_status = ST_NET_BUSY;
                end else begin
                    unique case (r_mode)
                        MODE_BACKOFF: begin
                            if (r_elapsed >= full_ext) begin
                                n_mode = MODE_IDLE;
                            end else if (r_elapsed < cd_ext) begin
                                n_status = ST_CD_BACKOFF;
                            end else begin
                                n_status = ST_PRIO_BACKOFF;
                            end
                        end
                        MODE_COLLISION: begin
                            if (r_coll_left == 16'd0) begin
                                n_mode   = MODE_BACKOFF;
                                n_status = ST_CD_BACKOFF;
                            end else begin
                                n_status = ST_COLLISION;
                            end
                        end
                        default: begin
                            n_mode = r_mode;
                        end
                    endcase
                    // Idle bus: either the line is busy or we win it
                    if (n_mode == MODE_IDLE) begin
                        if (i_in_item.line_busy) begin
                            n_mode    = MODE_BACKOFF;
                            n_elapsed = '0;
                            n_status  = ST_NET_BUSY;
                        end else begin
                            n_tx_active = 1'b1;
                            n_status    = ST_GRANTED;
                        end
                    end
                end
            end
            default: begin
                // Echo of a transmitted byte
                if (!r_tx_active) begin
                    n_status = mode_status(r_mode);
                end else if (echo_bad) begin
                    n_mode      = MODE_COLLISION;
                    n_coll_left = r_coll_hold;
                    n_coll_cnt  = r_coll_cnt + 32'd1;
                    n_tx_active = 1'b0;
                    n_break     = 1'b1;
                    n_status    = ST_COLLISION;
                end else if (i_in_item.last_byte) begin
                    n_pkt_cnt   = r_pkt_cnt + 32'd1;
                    n_mode      = MODE_BACKOFF;
                    n_elapsed   = '0;
                    n_tx_active = 1'b0;
                    n_status    = ST_IDLE;
                end else begin
                    n_status = ST_GRANTED;
                end
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_backoff <= CD_BACKOFF_RST;
            r_coll_hold  <= COLLISION_HOLD_RST;
            r_prio_tick  <= PRIO_TICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CD_BACKOFF:     r_cd_backoff <= i_cfg_data;
                CFG_COLLISION_HOLD: r_coll_hold  <= i_cfg_data;
                CFG_PRIO_TICK:      r_prio_tick  <= i_cfg_data[7:0];
                default:            r_prio_tick  <= r_prio_tick;
            endcase
        end
    end

    // Bus state update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_elapsed   <= '0;
            r_coll_left <= '0;
            r_tx_active <= 1'b0;
            r_pkt_cnt   <= '0;
            r_coll_cnt  <= '0;
        end else if (load) begin
            r_mode      <= n_mode;
            r_elapsed   <= n_elapsed;
            r_coll_left <= n_coll_left;
            r_tx_active <= n_tx_active;
            r_pkt_cnt   <= n_pkt_cnt;
            r_coll_cnt  <= n_coll_cnt;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item.status          <= n_status;
            r_out_item.send_break      <= n_break;
            r_out_item.packets_sent    <= n_pkt_cnt;
            r_out_item.collisions_seen <= n_coll_cnt;
        end
    end

    // Checks
    `CCBA_ASSERT(a_break_is_collision, o_out_valid && o_out_item.send_break |-> o_out_item.status == ST_COLLISION)
    `CCBA_ASSERT(a_break_counts_once, load && n_break |=> r_coll_cnt == $past(r_coll_cnt) + 32'd1)
    `CCBA_ASSERT(a_tx_only_from_grant, $rose(r_tx_active) |-> $past(n_status) == ST_GRANTED)
    `CCBA_ASSERT_RST(a_reset_empties_output, !i_rst_n |=> !o_out_valid)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    import ccba_pkg::*;

    localparam int ELAPSED_W = 20;

    // DUT inputs, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_item = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_CD_BACKOFF;
    logic [15:0] i_cfg_data = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_item;

    csma_cd_bus_access_controller #(
        .ELAPSED_BITS(ELAPSED_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Bus state mirror and register copies
    t_mode                pr_mode = MODE_IDLE;
    logic [ELAPSED_W-1:0] pr_elapsed = '0;
    logic [15:0]          pr_coll_left = '0;
    logic                 pr_tx_active = 1'b0;
    logic [31:0]          pr_pkt_cnt = '0;
    logic [31:0]          pr_coll_cnt = '0;
    logic [15:0]          cfg_cd_backoff = CD_BACKOFF_RST;
    logic [15:0]          cfg_coll_hold = COLLISION_HOLD_RST;
    logic [7:0]           cfg_prio_tick = PRIO_TICK_RST;

    t_in_item    event_q[$];
    t_out_item   bus_result_q[$];
    t_out_item   want;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_breaks = 0;
    int unsigned err_cnt = 0;
    int unsigned status_hits[0:7];

    initial begin
        foreach (status_hits[k]) status_hits[k] = 0;
    end

    function automatic logic [2:0] status_of_mode();
        case (pr_mode)
            MODE_BACKOFF:   return ST_CD_BACKOFF;
            MODE_COLLISION: return ST_COLLISION;
            default:        return ST_IDLE;
        endcase
    endfunction

    function automatic void rearm_backoff();
        pr_mode = MODE_BACKOFF;
        pr_elapsed = '0;
    endfunction

    // Advance the mirror by one bus event and return what the block must report
    function automatic t_out_item next_bus_result(input t_in_item ev);
        t_out_item   res;
        logic [32:0] full_wait;
        res = '0;
        case (ev.op)
            OP_TICK: begin
                if (pr_elapsed != '1) pr_elapsed++;
                if (pr_coll_left != 0) pr_coll_left--;
                if (pr_mode == MODE_BACKOFF && pr_elapsed >= cfg_cd_backoff)
                    pr_mode = MODE_IDLE;
                else if (pr_mode == MODE_COLLISION && pr_coll_left == 0)
                    pr_mode = MODE_BACKOFF;
                if (pr_mode == MODE_IDLE && ev.line_busy) rearm_backoff();
                res.status = status_of_mode();
            end
            OP_RX_BYTE: begin
                rearm_backoff();
                res.status = ST_CD_BACKOFF;
            end
            OP_SEND: begin
                if (pr_tx_active) begin
                    res.status = ST_NET_BUSY;
                end else if (pr_mode == MODE_BACKOFF) begin
                    full_wait = 33'(cfg_cd_backoff) + 33'(ev.prio_delay) * 33'(cfg_prio_tick);
                    if (33'(pr_elapsed) >= full_wait) pr_mode = MODE_IDLE;
                    else if (pr_elapsed < cfg_cd_backoff) res.status = ST_CD_BACKOFF;
                    else res.status = ST_PRIO_BACKOFF;
                end else if (pr_mode == MODE_COLLISION) begin
                    if (pr_coll_left == 0) begin
                        pr_mode = MODE_BACKOFF;
                        res.status = ST_CD_BACKOFF;
                    end else begin
                        res.status = ST_COLLISION;
                    end
                end
                // idle bus: either the line is busy or the packet may go
                if (!pr_tx_active && pr_mode == MODE_IDLE) begin
                    if (ev.line_busy) begin
                        rearm_backoff();
                        res.status = ST_NET_BUSY;
                    end else begin
                        pr_tx_active = 1'b1;
                        res.status = ST_GRANTED;
                    end
                end
            end
            default: begin
                if (!pr_tx_active) begin
                    res.status = status_of_mode();
                end else if (!ev.echo_present || ev.echo_byte != ev.tx_byte) begin
                    pr_mode = MODE_COLLISION;
                    pr_coll_left = cfg_coll_hold;
                    pr_coll_cnt++;
                    pr_tx_active = 1'b0;
                    res.send_break = 1'b1;
                    res.status = ST_COLLISION;
                end else if (ev.last_byte) begin
                    pr_pkt_cnt++;
                    rearm_backoff();
                    pr_tx_active = 1'b0;
                    res.status = ST_IDLE;
                end else begin
                    res.status = ST_GRANTED;
                end
            end
        endcase
        res.packets_sent = pr_pkt_cnt;
        res.collisions_seen = pr_coll_cnt;
        return res;
    endfunction

    // Driver: predict on acceptance, then present the next pending event
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                bus_result_q.push_back(next_bus_result(i_in_item));
                n_accepted++;
            end
            if (i_in_valid && !o_in_ready) begin
                i_in_valid <= 1'b1;
            end else if (event_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_item <= event_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_checked++;
                status_hits[o_out_item.status]++;
                if (o_out_item.send_break === 1'b1) n_breaks++;
                if (bus_result_q.size() == 0) begin
                    $error("unexpected result: status %0d", o_out_item.status);
                    err_cnt++;
                end else begin
                    want = bus_result_q.pop_front();
                    if (o_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               o_out_item.status);
                        err_cnt++;
                    end
                    if (o_out_item.send_break !== want.send_break) begin
                        $error("send_break: expected %0d, got %0d", want.send_break,
                               o_out_item.send_break);
                        err_cnt++;
                    end
                    if (o_out_item.packets_sent !== want.packets_sent) begin
                        $error("packets_sent: expected %0d, got %0d", want.packets_sent,
                               o_out_item.packets_sent);
                        err_cnt++;
                    end
                    if (o_out_item.collisions_seen !== want.collisions_seen) begin
                        $error("collisions_seen: expected %0d, got %0d",
                               want.collisions_seen, o_out_item.collisions_seen);
                        err_cnt++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_ev(input logic [1:0] op, input logic busy, input logic [7:0] prio,
                           input logic [7:0] txb, input logic [7:0] rxb,
                           input logic present, input logic last);
        t_in_item ev;
        ev.op = op;
        ev.line_busy = busy;
        ev.prio_delay = prio;
        ev.tx_byte = txb;
        ev.echo_byte = rxb;
        ev.echo_present = present;
        ev.last_byte = last;
        event_q.push_back(ev);
        n_queued++;
    endtask

    task automatic push_noise();
        push_ev(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom), 1'($urandom));
    endtask

    // One packet attempt: a random run of ticks, a send, then echoes of the bytes
    task automatic push_packet();
        int unsigned n_ticks;
        int unsigned n_bytes;
        int unsigned fault;
        logic [7:0]  txb;
        logic [7:0]  rxb;
        logic [7:0]  prio;
        logic        present;
        n_ticks = $urandom_range(0, cfg_cd_backoff + cfg_coll_hold + 4 * cfg_prio_tick + 3);
        for (int unsigned k = 0; k < n_ticks; k++) begin
            if ($urandom_range(0, 39) == 0)
                push_ev(OP_RX_BYTE, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        1'($urandom), 1'($urandom));
            else
                push_ev(OP_TICK, $urandom_range(0, 24) == 0, 8'($urandom), 8'($urandom),
                        8'($urandom), 1'($urandom), 1'($urandom));
        end
        prio = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        push_ev(OP_SEND, $urandom_range(0, 9) == 0, prio, 8'($urandom), 8'($urandom),
                1'($urandom), 1'($urandom));
        n_bytes = $urandom_range(1, 5);
        for (int unsigned k = 0; k < n_bytes; k++) begin
            txb = 8'($urandom);
            fault = $urandom_range(0, 14);
            present = 1'b1;
            rxb = txb;
            if (fault == 0) begin
                present = 1'b0;
                rxb = 8'($urandom);
            end else if (fault == 1) begin
                rxb = txb ^ 8'($urandom_range(1, 255));
            end
            push_ev(OP_ECHO, 1'($urandom), 8'($urandom), txb, rxb, present,
                    (k == n_bytes - 1) || ($urandom_range(0, 29) == 0));
        end
    endtask

    task automatic push_random(input int unsigned n);
        int unsigned stop_at;
        stop_at = n_queued + n;
        while (n_queued < stop_at) begin
            if ($urandom_range(0, 99) < 85) push_packet();
            else push_noise();
        end
    endtask

    // Hold off until every queued transaction has produced its result
    task automatic settle();
        while (n_checked < n_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CD_BACKOFF:     cfg_cd_backoff = val;
            CFG_COLLISION_HOLD: cfg_coll_hold = val;
            default:            cfg_prio_tick = val[7:0];
        endcase
    endtask

    task automatic set_bus_cfg(input logic [15:0] cd, input logic [15:0] hold,
                               input logic [7:0] ptick);
        settle();
        write_reg(CFG_CD_BACKOFF, cd);
        write_reg(CFG_COLLISION_HOLD, hold);
        write_reg(CFG_PRIO_TICK, {8'h00, ptick});
    endtask

    // Stimulus sequencing
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 51;

        // reset settings: stray echo, busy line, send during backoff, line byte
        push_ev(OP_ECHO, 1'b0, 8'h00, 8'h3C, 8'h3C, 1'b1, 1'b1);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_SEND, 1'b1, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_RX_BYTE, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);

        // short backoff: expiry, busy restart, clean packet, collision, prio wait
        set_bus_cfg(16'd2, 16'd2, 8'd1);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_TICK, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_ECHO, 1'b0, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b0);
        push_ev(OP_ECHO, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_ECHO, 1'b0, 8'h00, 8'hA5, 8'h5A, 1'b1, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_ECHO, 1'b0, 8'h00, 8'h81, 8'h81, 1'b0, 1'b1);

        // zero hold: collision already expired when a send comes in
        set_bus_cfg(16'd2, 16'd0, 8'd1);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        push_ev(OP_ECHO, 1'b0, 8'h00, 8'h12, 8'h13, 1'b1, 1'b1);
        push_ev(OP_ECHO, 1'b0, 8'h00, 8'h12, 8'h12, 1'b1, 1'b0);
        push_ev(OP_SEND, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);

        // random traffic, slow receiver
        set_bus_cfg(16'd4, 16'd3, 8'd2);
        push_random(400);

        // largest settings: only line events and refused sends
        set_bus_cfg(16'hFFFF, 16'hFFFF, 8'hFF);
        push_ev(OP_RX_BYTE, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        repeat (40)
            push_ev(2'($urandom_range(0, 2)), 1'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 1'($urandom), 1'($urandom));

        // smallest settings, slow sender
        set_bus_cfg(16'd0, 16'd0, 8'd0);
        send_idle_pct = 51;
        recv_idle_pct = 13;
        push_random(300);

        // full rate, with a pause for all results halfway
        set_bus_cfg(16'd6, 16'd5, 8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(250);
        settle();
        push_random(250);

        settle();
        repeat (8) @(posedge i_clk);
        if (bus_result_q.size() != 0) begin
            $error("%0d expected results never arrived", bus_result_q.size());
            err_cnt++;
        end
        $display("bus events accepted: %0d, results checked: %0d, breaks: %0d",
                 n_accepted, n_checked, n_breaks);
        $display("status seen: idle %0d, cd %0d, prio %0d, coll %0d, busy %0d, grant %0d",
                 status_hits[ST_IDLE], status_hits[ST_CD_BACKOFF],
                 status_hits[ST_PRIO_BACKOFF], status_hits[ST_COLLISION],
                 status_hits[ST_NET_BUSY], status_hits[ST_GRANTED]);
        if (err_cnt == 0) begin
            $display("** csma_cd_bus_access_controller: PASSED **");
        end else begin
            $display("** csma_cd_bus_access_controller: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("** csma_cd_bus_access_controller: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
